/* sv/cbts_pkg.sv */
package cbts_pkg;

   localparam int unsigned CLK_W    = 27;
   localparam int unsigned RATE_W   = 20;
   localparam int unsigned DIVD_W   = 4;
   localparam int unsigned WORD_W   = 15;
   localparam int unsigned QNT_W    = 6;
   localparam int unsigned SEG_W    = 5;
   localparam int unsigned STEP_W   = 10;
   localparam int unsigned PROD_W   = 14;
   localparam int unsigned CNT_W    = 5;

   localparam logic [CLK_W-1:0]  CLK_RESET = CLK_W'(48000000);
   localparam logic [CNT_W-1:0]  DIV_LAST  = CNT_W'(CLK_W - 1);
   localparam logic [SEG_W-1:0]  SEG_MIN   = SEG_W'(3);
   localparam logic [SEG_W-1:0]  SEG_MAX   = SEG_W'(17);
   localparam logic [QNT_W-1:0]  QNT_MIN   = QNT_W'(1);
   localparam logic [QNT_W-1:0]  QNT_MAX   = QNT_W'(32);
   localparam logic [DIVD_W-1:0] DIVD_MAX  = DIVD_W'(15);
   localparam logic [1:0]        SJW_MAX   = 2'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SEARCH,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic start;
      logic div_step;
      logic search_step;
      logic res_load;
      logic rsp_load;
   } cmd_type;

   typedef struct packed {
      logic rate_zero;
      logic div_last;
      logic match;
      logic cand_last;
   } status_type;

endpackage

/* sv/can_bit_timing_search_top.sv */
// channel  direction  handshake             payload
// req      in         req_valid/req_stall   req_bit_rate[19:0]
// rsp      out        rsp_valid/rsp_stall   rsp_found, rsp_clock_divider[3:0],
//                                           rsp_timing_word[14:0]
// csr      in         csr_wr_en             csr_wr_data[26:0]
//
// One item at a time: accept in idle, a bit-serial divide of the clock by
// the rate, then one candidate a cycle (up to 7680), then the output load.
// A zero rate skips divide and search.
// Synchronous reset sets the clock register to 48000000 and idles the block.
// A result held by rsp_stall does not block the next accept; a finished
// search waits only for the output register to free.
module can_bit_timing_search_top
   import cbts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CLK_W-1:0]  csr_wr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [RATE_W-1:0] req_bit_rate,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_found,
   output logic [DIVD_W-1:0] rsp_clock_divider,
   output logic [WORD_W-1:0] rsp_timing_word
);

   cmd_type    cmd;
   status_type status;

   cbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cbts_dpath u_dpath (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_bit_rate      (req_bit_rate),
      .cmd               (cmd),
      .status            (status),
      .rsp_found         (rsp_found),
      .rsp_clock_divider (rsp_clock_divider),
      .rsp_timing_word   (rsp_timing_word)
   );

endmodule

/* sv/cbts_ctrl.sv */
module cbts_ctrl
   import cbts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = status.rate_zero ? ST_DONE : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (status.match) begin
               cmd.res_load = 1'b1;
               state_in     = ST_DONE;
            end else if (status.cand_last) begin
               state_in = ST_DONE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* sv/cbts_dpath.sv */
module cbts_dpath
   import cbts_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [CLK_W-1:0]  csr_wr_data,
   input  logic [RATE_W-1:0] req_bit_rate,
   input  cmd_type           cmd,
   output status_type        status,
   output logic              rsp_found,
   output logic [DIVD_W-1:0] rsp_clock_divider,
   output logic [WORD_W-1:0] rsp_timing_word
);

   logic [CLK_W-1:0]  clk_hz_ff;
   logic [RATE_W-1:0] divisor_ff;
   logic [RATE_W-1:0] rem_ff, rem_in;
   logic [CLK_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [RATE_W:0]   trial;
   logic [RATE_W:0]   diff;

   logic [DIVD_W-1:0] d_ff, d_in;
   logic [QNT_W-1:0]  q_ff, q_in;
   logic [SEG_W-1:0]  s_ff, s_in;
   logic [STEP_W-1:0] step_ff, step_in, step_next;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [DIVD_W:0]   d_plus1;

   logic [3:0]        r_seg;
   logic [2:0]        seg1;
   logic [2:0]        seg2;
   logic [1:0]        sjw;
   logic [QNT_W-1:0]  q_minus1;

   logic              res_found_ff;
   logic [DIVD_W-1:0] res_div_ff;
   logic [WORD_W-1:0] res_word_ff;
   logic              rsp_found_ff;
   logic [DIVD_W-1:0] rsp_div_ff;
   logic [WORD_W-1:0] rsp_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clk_hz_ff <= CLK_RESET;
      end else if (csr_wr_en) begin
         clk_hz_ff <= csr_wr_data;
      end
   end

   // restoring divide, one quotient bit a cycle
   assign trial  = {rem_ff, quo_ff[CLK_W-1]};
   assign diff   = trial - {1'b0, divisor_ff};
   assign rem_in = diff[RATE_W] ? trial[RATE_W-1:0] : diff[RATE_W-1:0];
   assign quo_in = {quo_ff[CLK_W-2:0], ~diff[RATE_W]};

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         divisor_ff <= req_bit_rate;
         rem_ff     <= '0;
         quo_ff     <= clk_hz_ff;
         cnt_ff     <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // walk candidates; product kept as a running sum
   assign d_plus1 = {1'b0, d_ff} + (DIVD_W+1)'(1);

   always_comb begin
      d_in      = d_ff;
      q_in      = q_ff;
      s_in      = s_ff;
      step_in   = step_ff;
      prod_in   = prod_ff;
      step_next = step_ff;
      if (s_ff != SEG_MAX) begin
         s_in    = s_ff + SEG_W'(1);
         prod_in = prod_ff + PROD_W'(step_ff);
      end else begin
         s_in = SEG_MIN;
         if (q_ff != QNT_MAX) begin
            q_in      = q_ff + QNT_W'(1);
            step_next = step_ff + STEP_W'(d_plus1);
         end else begin
            q_in      = QNT_MIN;
            d_in      = d_ff + DIVD_W'(1);
            step_next = STEP_W'(d_plus1) + STEP_W'(1);
         end
         step_in = step_next;
         prod_in = PROD_W'({step_next, 1'b0}) + PROD_W'(step_next);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         d_ff    <= '0;
         q_ff    <= QNT_MIN;
         s_ff    <= SEG_MIN;
         step_ff <= STEP_W'(1);
         prod_ff <= PROD_W'(3);
      end else if (cmd.search_step) begin
         d_ff    <= d_in;
         q_ff    <= q_in;
         s_ff    <= s_in;
         step_ff <= step_in;
         prod_ff <= prod_in;
      end
   end

   assign r_seg    = 4'(s_ff - SEG_MIN);
   assign seg1     = r_seg[3:1];
   assign seg2     = 3'(r_seg - {1'b0, seg1});
   assign sjw      = (seg1 > {1'b0, SJW_MAX}) ? SJW_MAX : seg1[1:0];
   assign q_minus1 = q_ff - QNT_W'(1);

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         res_found_ff <= 1'b0;
         res_div_ff   <= '0;
         res_word_ff  <= '0;
      end else if (cmd.res_load) begin
         res_found_ff <= 1'b1;
         res_div_ff   <= d_ff;
         res_word_ff  <= {seg2, {1'b0, seg1}, sjw, q_minus1};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_found_ff <= res_found_ff;
         rsp_div_ff   <= res_div_ff;
         rsp_word_ff  <= res_word_ff;
      end
   end

   assign status.rate_zero = (req_bit_rate == '0);
   assign status.div_last  = (cnt_ff == DIV_LAST);
   assign status.match     = (quo_ff == CLK_W'(prod_ff));
   assign status.cand_last = (s_ff == SEG_MAX) && (q_ff == QNT_MAX) && (d_ff == DIVD_MAX);

   assign rsp_found         = rsp_found_ff;
   assign rsp_clock_divider = rsp_div_ff;
   assign rsp_timing_word   = rsp_word_ff;

endmodule
